[design/gbn_pkg.sv]
// gbn_pkg: shared widths, codes and types of the go-back-n sender window
// used by the channel interfaces, the controller and the datapath
`default_nettype none

package gbn_pkg;

  // sizing of the window and the descriptor store
  localparam int unsigned WINDOW_MAX  = 16;
  localparam int unsigned PAYLOAD_MAX = 1024;
  localparam int unsigned SLOT_BITS   = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int unsigned CNT_BITS    = $clog2(WINDOW_MAX + 1);

  // field widths
  localparam int unsigned CMD_BITS      = 2;
  localparam int unsigned SEQ_BITS      = 16;
  localparam int unsigned TAG_BITS      = 16;
  localparam int unsigned LEN_BITS      = 11;
  localparam int unsigned KIND_BITS     = 3;
  localparam int unsigned OUTST_BITS    = 5;
  localparam int unsigned MS_BITS       = 16;
  localparam int unsigned WIN_REG_BITS  = 5;
  localparam int unsigned CFG_IDX_BITS  = 2;
  localparam int unsigned CFG_DATA_BITS = 16;

  // timing and reset values
  localparam int unsigned TICK_MS       = 10;
  localparam int unsigned WINDOW_RESET  = 16;
  localparam int unsigned TIMEOUT_RESET = 200;
  localparam int unsigned SEQ_RESET     = 1;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_OFFER = 2'd0,
    CMD_ACK   = 2'd1,
    CMD_TICK  = 2'd2
  } cmd_e;

  typedef enum logic [KIND_BITS-1:0] {
    KIND_SENT      = 3'd0,
    KIND_RETX      = 3'd1,
    KIND_REFUSED   = 3'd2,
    KIND_ACK_TAKEN = 3'd3,
    KIND_ACK_IGNOR = 3'd4,
    KIND_TICK_ONLY = 3'd5
  } kind_e;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_WINDOW_SIZE = 2'd0,
    REG_TIMEOUT_MS  = 2'd1
  } reg_e;

  // controller to datapath
  typedef struct packed {
    logic latch;      // take the input item into the work registers
    logic exec;       // carry out a single-result step and load the result
    logic rtx_start;  // restart timer and set up the resend walk
    logic rtx_emit;   // load one resent packet into the result register
  } gbn_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic rtx_go;     // timeout with packets outstanding
    logic rtx_last;   // current resend is the final one
  } gbn_sts_t;

  typedef struct packed {
    kind_e                 kind;
    logic [SEQ_BITS-1:0]   seq_num;
    logic [TAG_BITS-1:0]   out_tag;
    logic [LEN_BITS-1:0]   out_len;
    logic                  last;
    logic [OUTST_BITS-1:0] outstanding;
    logic                  timer_running;
  } gbn_res_t;

endpackage

`default_nettype wire

[design/gbn_in_if.sv]
// gbn_in_if: command channel into the sender window (valid/ready)
// depends on gbn_pkg for field widths
`default_nettype none

interface gbn_in_if import gbn_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CMD_BITS-1:0] command;
  logic [TAG_BITS-1:0] payload_tag;
  logic [LEN_BITS-1:0] payload_len;
  logic [SEQ_BITS-1:0] ack_seq;

  modport source (output valid, output command, output payload_tag, output payload_len,
                  output ack_seq, input ready);
  modport sink (input valid, input command, input payload_tag, input payload_len,
                input ack_seq, output ready);
endinterface

`default_nettype wire

[design/gbn_out_if.sv]
// gbn_out_if: result channel out of the sender window (valid/ready)
// depends on gbn_pkg for field widths
`default_nettype none

interface gbn_out_if import gbn_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [KIND_BITS-1:0]  kind;
  logic [SEQ_BITS-1:0]   seq_num;
  logic [TAG_BITS-1:0]   out_tag;
  logic [LEN_BITS-1:0]   out_len;
  logic                  last;
  logic [OUTST_BITS-1:0] outstanding;
  logic                  timer_running;

  modport source (output valid, output kind, output seq_num, output out_tag, output out_len,
                  output last, output outstanding, output timer_running, input ready);
  modport sink (input valid, input kind, input seq_num, input out_tag, input out_len,
                input last, input outstanding, input timer_running, output ready);
endinterface

`default_nettype wire

[design/gbn_cfg_if.sv]
// gbn_cfg_if: register write channel of the sender window (valid/ready)
// depends on gbn_pkg for index and data widths
`default_nettype none

interface gbn_cfg_if import gbn_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_BITS-1:0]  index;
  logic [CFG_DATA_BITS-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[design/gbn_ram.sv]
// gbn_ram: generic single-write, single-read RAM with registered read data
// no package dependency
`default_nettype none

module gbn_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [ADDR_BITS-1:0] waddr_i,
  input  logic [WIDTH-1:0]     wdata_i,
  input  logic [ADDR_BITS-1:0] raddr_i,
  output logic [WIDTH-1:0]     rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

[design/gbn_ctrl.sv]
// gbn_ctrl: sequencing state machine of the sender window
// depends on gbn_pkg for the command and status structs
`default_nettype none

module gbn_ctrl import gbn_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  logic     out_ready_i,
  output logic     out_valid_o,
  input  gbn_sts_t sts_i,
  output gbn_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RETX
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   out_free;

  // result register can take a new item this cycle
  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.latch = in_valid_i;
      end
      ST_EXEC: begin
        if (out_free) begin
          cmd_o.rtx_start = sts_i.rtx_go;
          cmd_o.exec      = !sts_i.rtx_go;
        end
      end
      ST_RETX: begin
        cmd_o.rtx_emit = out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (out_free) begin
            state_q <= sts_i.rtx_go ? ST_RETX : ST_IDLE;
          end
        end
        ST_RETX: begin
          if (out_free && sts_i.rtx_last) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase

      if (cmd_o.exec || cmd_o.rtx_emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

[design/gbn_datapath.sv]
// gbn_datapath: window registers, timer, configuration and descriptor store
// depends on gbn_pkg and gbn_ram
`default_nettype none

module gbn_datapath import gbn_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  gbn_cmd_t                 cmd_i,
  output gbn_sts_t                 sts_o,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i,
  input  logic [CMD_BITS-1:0]      command_i,
  input  logic [TAG_BITS-1:0]      payload_tag_i,
  input  logic [LEN_BITS-1:0]      payload_len_i,
  input  logic [SEQ_BITS-1:0]      ack_seq_i,
  output gbn_res_t                 res_o
);

  localparam int unsigned DESC_BITS = TAG_BITS + LEN_BITS;

  // latched item
  cmd_e                cmd_q;
  logic [TAG_BITS-1:0] tag_q;
  logic [LEN_BITS-1:0] len_q;
  logic [SEQ_BITS-1:0] ack_q;

  // window state
  logic [SEQ_BITS-1:0]  base_q, base_d;
  logic [SEQ_BITS-1:0]  next_q, next_d;
  logic [SLOT_BITS-1:0] head_q, head_d;
  logic [MS_BITS-1:0]   elapsed_q, elapsed_d;
  logic                 timer_on_q, timer_on_d;
  logic [CNT_BITS-1:0]  k_q, k_d;
  logic [CNT_BITS-1:0]  n_q, n_d;

  // configuration
  logic [WIN_REG_BITS-1:0] win_q;
  logic [MS_BITS-1:0]      tmo_q;

  gbn_res_t res_q, res_d;

  logic [SEQ_BITS-1:0]  inflight, eff_win, off;
  logic                 window_full, ack_in_range, timeout_hit;
  logic [MS_BITS:0]     elapsed_sum;
  logic [MS_BITS-1:0]   elapsed_new;
  logic [LEN_BITS-1:0]  len_clamped;
  logic [SLOT_BITS-1:0] wr_slot, ack_head, rd_slot;
  logic [CNT_BITS-1:0]  n_retx;
  logic                 ram_we;
  logic [DESC_BITS-1:0] ram_rdata;
  logic [SEQ_BITS-1:0]  outst_full;

  // a slot sum below twice the depth folds back with one subtract
  function automatic logic [SLOT_BITS-1:0] wrap_slot(input logic [SLOT_BITS:0] s);
    logic [SLOT_BITS:0] r;
    r = s;
    if (s >= (SLOT_BITS + 1)'(WINDOW_MAX)) begin
      r = s - (SLOT_BITS + 1)'(WINDOW_MAX);
    end
    return r[SLOT_BITS-1:0];
  endfunction

  assign inflight = next_q - base_q;
  assign off      = ack_q - base_q;

  always_comb begin
    eff_win = SEQ_BITS'(win_q);
    if (win_q == '0) begin
      eff_win = SEQ_BITS'(1);
    end else if (SEQ_BITS'(win_q) > SEQ_BITS'(WINDOW_MAX)) begin
      eff_win = SEQ_BITS'(WINDOW_MAX);
    end
  end

  assign window_full  = (inflight >= eff_win);
  assign ack_in_range = (off < inflight);

  // saturating tick accumulation
  assign elapsed_sum = {1'b0, elapsed_q} + (MS_BITS + 1)'(TICK_MS);
  assign elapsed_new = elapsed_sum[MS_BITS] ? '1 : elapsed_sum[MS_BITS-1:0];
  assign timeout_hit = timer_on_q && (elapsed_new >= tmo_q);

  always_comb begin
    len_clamped = len_q;
    if (len_q == '0) begin
      len_clamped = LEN_BITS'(1);
    end else if (len_q > LEN_BITS'(PAYLOAD_MAX)) begin
      len_clamped = LEN_BITS'(PAYLOAD_MAX);
    end
  end

  assign wr_slot  = wrap_slot({1'b0, head_q} + (SLOT_BITS + 1)'(inflight));
  assign ack_head = wrap_slot({1'b0, head_q} + (SLOT_BITS + 1)'(off) +
                              (SLOT_BITS + 1)'(1));
  assign n_retx   = (inflight > SEQ_BITS'(WINDOW_MAX)) ? CNT_BITS'(WINDOW_MAX)
                                                       : inflight[CNT_BITS-1:0];

  always_comb begin
    k_d = k_q;
    if (cmd_i.latch) begin
      k_d = '0;
    end else if (cmd_i.rtx_emit) begin
      k_d = k_q + CNT_BITS'(1);
    end
  end

  // read address follows the next walk index so the registered read data is ready when the walk reaches it
  assign rd_slot = wrap_slot({1'b0, head_q} + (SLOT_BITS + 1)'(k_d));

  assign sts_o.rtx_go   = (cmd_q == CMD_TICK) && timeout_hit && (inflight != '0);
  assign sts_o.rtx_last = ((k_q + CNT_BITS'(1)) == n_q);

  assign ram_we = cmd_i.exec && (cmd_q == CMD_OFFER) && !window_full;

  gbn_ram #(
    .WIDTH (DESC_BITS),
    .DEPTH (WINDOW_MAX)
  ) u_desc_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_slot),
    .wdata_i ({tag_q, len_clamped}),
    .raddr_i (rd_slot),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    base_d     = base_q;
    next_d     = next_q;
    head_d     = head_q;
    elapsed_d  = elapsed_q;
    timer_on_d = timer_on_q;
    n_d        = n_q;
    res_d      = res_q;

    if (cmd_i.exec) begin
      res_d.kind    = KIND_TICK_ONLY;
      res_d.seq_num = base_q;
      res_d.out_tag = '0;
      res_d.out_len = '0;
      res_d.last    = 1'b1;
      unique case (cmd_q)
        CMD_OFFER: begin
          if (window_full) begin
            res_d.kind = KIND_REFUSED;
          end else begin
            next_d        = next_q + SEQ_BITS'(1);
            res_d.kind    = KIND_SENT;
            res_d.seq_num = next_q;
            res_d.out_tag = tag_q;
            res_d.out_len = len_clamped;
            if (inflight == '0) begin
              elapsed_d  = '0;
              timer_on_d = 1'b1;
            end
          end
        end
        CMD_ACK: begin
          if (ack_in_range) begin
            base_d        = ack_q + SEQ_BITS'(1);
            head_d        = ack_head;
            res_d.kind    = KIND_ACK_TAKEN;
            res_d.seq_num = base_d;
            if (base_d == next_q) begin
              timer_on_d = 1'b0;
            end else begin
              elapsed_d  = '0;
              timer_on_d = 1'b1;
            end
          end else begin
            res_d.kind = KIND_ACK_IGNOR;
          end
        end
        CMD_TICK: begin
          // a timeout with nothing outstanding only restarts the timer
          elapsed_d = timeout_hit ? '0 : elapsed_new;
        end
        default: begin
          res_d.kind = KIND_TICK_ONLY;
        end
      endcase
    end else if (cmd_i.rtx_start) begin
      elapsed_d  = '0;
      timer_on_d = 1'b1;
      n_d        = n_retx;
    end else if (cmd_i.rtx_emit) begin
      res_d.kind    = KIND_RETX;
      res_d.seq_num = base_q + SEQ_BITS'(k_q);
      res_d.out_tag = ram_rdata[DESC_BITS-1:LEN_BITS];
      res_d.out_len = ram_rdata[LEN_BITS-1:0];
      res_d.last    = sts_o.rtx_last;
    end

    outst_full          = next_d - base_d;
    res_d.outstanding   = outst_full[OUTST_BITS-1:0];
    res_d.timer_running = timer_on_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q     <= SEQ_BITS'(SEQ_RESET);
      next_q     <= SEQ_BITS'(SEQ_RESET);
      head_q     <= '0;
      elapsed_q  <= '0;
      timer_on_q <= 1'b0;
      k_q        <= '0;
      n_q        <= '0;
      win_q      <= WIN_REG_BITS'(WINDOW_RESET);
      tmo_q      <= MS_BITS'(TIMEOUT_RESET);
    end else begin
      base_q     <= base_d;
      next_q     <= next_d;
      head_q     <= head_d;
      elapsed_q  <= elapsed_d;
      timer_on_q <= timer_on_d;
      k_q        <= k_d;
      n_q        <= n_d;
      if (cfg_we_i && (cfg_idx_i == REG_WINDOW_SIZE)) begin
        win_q <= cfg_data_i[WIN_REG_BITS-1:0];
      end
      if (cfg_we_i && (cfg_idx_i == REG_TIMEOUT_MS)) begin
        tmo_q <= cfg_data_i[MS_BITS-1:0];
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      cmd_q <= cmd_e'(command_i);
      tag_q <= payload_tag_i;
      len_q <= payload_len_i;
      ack_q <= ack_seq_i;
    end
    if (cmd_i.exec || cmd_i.rtx_emit) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

`default_nettype wire

[design/go_back_n_sender_window_core.sv]
// Go-back-N sender window: command in, result items out, register write port
// An offer, an ack or a tick passes two steps: the idle state takes the item,
// the execute state carries it out into the result register; no new item is
// taken until both are done. A timeout with packets outstanding restarts the
// timer and then resends them through the single read port of the descriptor
// RAM, feeding one entry a cycle, oldest first, while results are taken. A new
// item is taken while the last result still waits in the output register.
// The descriptor store needs no clearing after reset; the register port is
// always ready and should be written only while the block is idle.
`default_nettype none

module go_back_n_sender_window_core import gbn_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  gbn_in_if.sink    in_i,
  gbn_out_if.source out_o,
  gbn_cfg_if.sink   cfg_i
);

  gbn_cmd_t cmd;
  gbn_sts_t sts;
  gbn_res_t res;

  assign cfg_i.ready = 1'b1;

  gbn_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  gbn_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .cfg_we_i      (cfg_i.valid),
    .cfg_idx_i     (cfg_i.index),
    .cfg_data_i    (cfg_i.data),
    .command_i     (in_i.command),
    .payload_tag_i (in_i.payload_tag),
    .payload_len_i (in_i.payload_len),
    .ack_seq_i     (in_i.ack_seq),
    .res_o         (res)
  );

  assign out_o.kind          = res.kind;
  assign out_o.seq_num       = res.seq_num;
  assign out_o.out_tag       = res.out_tag;
  assign out_o.out_len       = res.out_len;
  assign out_o.last          = res.last;
  assign out_o.outstanding   = res.outstanding;
  assign out_o.timer_running = res.timer_running;

endmodule

`default_nettype wire

[tb/go_back_n_sender_window_core_test.sv]
// go_back_n_sender_window_core_test: self-checking bench for the go-back-n sender window
// drives offers, acks and ticks through gbn_in_if, checks results against a window tracker
// depends on gbn_pkg, gbn_in_if, gbn_out_if, gbn_cfg_if and go_back_n_sender_window_core
`timescale 1ns / 1ps

module go_back_n_sender_window_core_test;
  import gbn_pkg::*;

  localparam logic [CMD_BITS-1:0] CMD_SPARE = 2'd3;  // unused command code
  localparam int unsigned LONG_TICKS  = 20;         // ticks under the longest timeout
  localparam int unsigned HOLD_CYCLES = 120;
  localparam int unsigned TAIL_CYCLES = 40;
  localparam int unsigned STALL_LIMIT = 2000;

  class sender_window_scoreboard;
    logic [WIN_REG_BITS-1:0] win_reg;
    logic [MS_BITS-1:0]      rto_reg;
    logic [SEQ_BITS-1:0]     win_base;
    logic [SEQ_BITS-1:0]     win_next;
    logic [TAG_BITS-1:0]     desc_tag [WINDOW_MAX];
    logic [LEN_BITS-1:0]     desc_len [WINDOW_MAX];
    int unsigned             oldest_slot;
    int unsigned             timer_ms;
    bit                      timer_live;
    gbn_res_t                awaited[$];
    int unsigned             failures;

    function new();
      win_reg     = WIN_REG_BITS'(WINDOW_RESET);
      rto_reg     = MS_BITS'(TIMEOUT_RESET);
      win_base    = SEQ_BITS'(SEQ_RESET);
      win_next    = SEQ_BITS'(SEQ_RESET);
      oldest_slot = 0;
      timer_ms    = 0;
      timer_live  = 1'b0;
      failures    = 0;
    endfunction

    function int unsigned in_flight();
      logic [SEQ_BITS-1:0] span;
      span = win_next - win_base;
      return span;
    endfunction

    function int unsigned window_limit();
      if (win_reg == 0) return 1;
      if (win_reg > WINDOW_MAX) return WINDOW_MAX;
      return win_reg;
    endfunction

    function int unsigned pending();
      return awaited.size();
    endfunction

    function void restart_timer();
      timer_ms   = 0;
      timer_live = 1'b1;
    endfunction

    function void push_result(kind_e kind, logic [SEQ_BITS-1:0] seq, logic [TAG_BITS-1:0] tag,
                              logic [LEN_BITS-1:0] len, logic last);
      gbn_res_t r;
      r.kind          = kind;
      r.seq_num       = seq;
      r.out_tag       = tag;
      r.out_len       = len;
      r.last          = last;
      r.outstanding   = OUTST_BITS'(in_flight());
      r.timer_running = timer_live;
      awaited.push_back(r);
    endfunction

    function void note_reg_write(reg_e idx, logic [CFG_DATA_BITS-1:0] data);
      if (idx == REG_WINDOW_SIZE) win_reg = data[WIN_REG_BITS-1:0];
      else if (idx == REG_TIMEOUT_MS) rto_reg = data[MS_BITS-1:0];
    endfunction

    function void note_command(logic [CMD_BITS-1:0] cmd, logic [TAG_BITS-1:0] tag,
                               logic [LEN_BITS-1:0] len, logic [SEQ_BITS-1:0] ack);
      int unsigned span;
      int unsigned slot;
      logic [LEN_BITS-1:0] plen;
      logic [SEQ_BITS-1:0] off;
      logic [SEQ_BITS-1:0] seq;
      span = in_flight();
      case (cmd)
        CMD_OFFER: begin
          if (span >= window_limit()) begin
            push_result(KIND_REFUSED, win_base, '0, '0, 1'b1);
          end else begin
            plen = len;
            if (plen == 0) plen = LEN_BITS'(1);
            if (plen > PAYLOAD_MAX) plen = LEN_BITS'(PAYLOAD_MAX);
            slot = (oldest_slot + span) % WINDOW_MAX;
            desc_tag[slot] = tag;
            desc_len[slot] = plen;
            seq = win_next;
            if (span == 0) restart_timer();
            win_next = win_next + 1'b1;
            push_result(KIND_SENT, seq, tag, plen, 1'b1);
          end
        end
        CMD_ACK: begin
          off = ack - win_base;
          if (off >= span) begin
            push_result(KIND_ACK_IGNOR, win_base, '0, '0, 1'b1);
          end else begin
            oldest_slot = (oldest_slot + off + 1) % WINDOW_MAX;
            win_base    = ack + 1'b1;
            if (win_base == win_next) timer_live = 1'b0;
            else restart_timer();
            push_result(KIND_ACK_TAKEN, win_base, '0, '0, 1'b1);
          end
        end
        CMD_TICK: begin
          timer_ms = timer_ms + TICK_MS;
          if (timer_ms > 32'hFFFF) timer_ms = 32'hFFFF;
          if (!timer_live || timer_ms < rto_reg) begin
            push_result(KIND_TICK_ONLY, win_base, '0, '0, 1'b1);
          end else begin
            restart_timer();
            if (span == 0) begin
              push_result(KIND_TICK_ONLY, win_base, '0, '0, 1'b1);
            end else begin
              if (span > WINDOW_MAX) span = WINDOW_MAX;
              // whole window goes out again, oldest first
              for (int unsigned k = 0; k < span; k++) begin
                slot = (oldest_slot + k) % WINDOW_MAX;
                push_result(KIND_RETX, win_base + SEQ_BITS'(k), desc_tag[slot], desc_len[slot],
                            k + 1 == span);
              end
            end
          end
        end
        default: push_result(KIND_TICK_ONLY, win_base, '0, '0, 1'b1);
      endcase
    endfunction

    function string show(gbn_res_t r);
      return $sformatf("kind %0d seq %0d tag %0d len %0d last %0b outst %0d timer %0b",
                       r.kind, r.seq_num, r.out_tag, r.out_len, r.last, r.outstanding,
                       r.timer_running);
    endfunction

    function void log_failure(string msg);
      failures++;
      if (failures <= 10) $display("%s", msg);
    endfunction

    function void check_result(gbn_res_t got);
      gbn_res_t want;
      if (awaited.size() == 0) begin
        log_failure({"result with nothing awaited: ", show(got)});
        return;
      end
      want = awaited.pop_front();
      if (got.kind !== want.kind || got.seq_num !== want.seq_num ||
          got.out_tag !== want.out_tag || got.out_len !== want.out_len ||
          got.last !== want.last || got.outstanding !== want.outstanding ||
          got.timer_running !== want.timer_running)
        log_failure({"result mismatch: expected ", show(want), " / got ", show(got)});
    endfunction

    function void flush_leftovers();
      gbn_res_t r;
      while (awaited.size() != 0) begin
        r = awaited.pop_front();
        log_failure({"result never arrived: ", show(r)});
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  gbn_in_if  in_bus ();
  gbn_out_if res_bus ();
  gbn_cfg_if reg_bus ();

  go_back_n_sender_window_core i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (res_bus),
    .cfg_i  (reg_bus)
  );

  sender_window_scoreboard sb = new();

  int unsigned src_idle_pct = 15;
  int unsigned snk_idle_pct = 15;
  bit          quiet_tail   = 1'b0;
  bit          hold_req     = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic send_item(input logic [CMD_BITS-1:0] cmd, input logic [TAG_BITS-1:0] tag,
                           input logic [LEN_BITS-1:0] len, input logic [SEQ_BITS-1:0] ack);
    int unsigned gap;
    @(negedge clk_i);
    if (!quiet_tail && $urandom_range(0, 99) < src_idle_pct) begin
      gap = $urandom_range(1, 3);
      in_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_bus.valid       <= 1'b1;
    in_bus.command     <= cmd;
    in_bus.payload_tag <= tag;
    in_bus.payload_len <= len;
    in_bus.ack_seq     <= ack;
    do @(posedge clk_i); while (in_bus.ready !== 1'b1);
    sb.note_command(cmd, tag, len, ack);
  endtask

  task automatic send_tick();
    send_item(CMD_TICK, TAG_BITS'($urandom), LEN_BITS'($urandom), SEQ_BITS'($urandom));
  endtask

  // drop the command channel and let every awaited result come out
  task automatic wait_idle();
    @(negedge clk_i);
    in_bus.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_e idx, input logic [CFG_DATA_BITS-1:0] data);
    @(negedge clk_i);
    reg_bus.valid <= 1'b1;
    reg_bus.index <= idx;
    reg_bus.data  <= data;
    do @(posedge clk_i); while (reg_bus.ready !== 1'b1);
    sb.note_reg_write(idx, data);
    @(negedge clk_i);
    reg_bus.valid <= 1'b0;
  endtask

  task automatic run_phase(input logic [CFG_DATA_BITS-1:0] win_data,
                           input logic [CFG_DATA_BITS-1:0] rto_data,
                           input int unsigned n_items, input int unsigned offer_pct,
                           input int unsigned ack_pct, input int unsigned tick_pct,
                           input int unsigned src_pct, input int unsigned snk_pct,
                           input int hold_at);
    int unsigned roll;
    int unsigned span;
    logic [SEQ_BITS-1:0] ack;
    logic [LEN_BITS-1:0] len;
    wait_idle();
    write_reg(REG_WINDOW_SIZE, win_data);
    write_reg(REG_TIMEOUT_MS, rto_data);
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    for (int i = 0; i < n_items; i++) begin
      if (i == hold_at) hold_req = 1'b1;
      roll = $urandom_range(0, 99);
      if ($urandom_range(0, 9) == 0) len = LEN_BITS'($urandom_range(0, 2047));
      else len = LEN_BITS'($urandom_range(1, PAYLOAD_MAX));
      span = sb.in_flight();
      // mostly acks that land inside the outstanding range
      case ($urandom_range(0, 9))
        0: ack = SEQ_BITS'($urandom);
        1: ack = sb.win_base - 1'b1;
        2: ack = sb.win_next;
        default: begin
          if (span == 0) ack = SEQ_BITS'($urandom);
          else ack = sb.win_base + SEQ_BITS'($urandom_range(0, span - 1));
        end
      endcase
      if (roll < offer_pct)
        send_item(CMD_OFFER, TAG_BITS'($urandom), len, SEQ_BITS'($urandom));
      else if (roll < offer_pct + ack_pct)
        send_item(CMD_ACK, TAG_BITS'($urandom), len, ack);
      else if (roll < offer_pct + ack_pct + tick_pct)
        send_tick();
      else
        send_item(CMD_SPARE, TAG_BITS'($urandom), len, SEQ_BITS'($urandom));
    end
  endtask

  // result side: random ready bursts plus one long hold-off on request
  initial begin : result_sink
    int unsigned gap;
    res_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        res_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
      end else if (!quiet_tail && $urandom_range(0, 99) < snk_idle_pct) begin
        gap = $urandom_range(1, 3);
        res_bus.ready <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end else begin
        res_bus.ready <= 1'b1;
      end
    end
  end

  initial begin : result_monitor
    gbn_res_t got;
    forever begin
      @(posedge clk_i);
      if (rst_ni && res_bus.valid === 1'b1 && res_bus.ready === 1'b1) begin
        got.kind          = kind_e'(res_bus.kind);
        got.seq_num       = res_bus.seq_num;
        got.out_tag       = res_bus.out_tag;
        got.out_len       = res_bus.out_len;
        got.last          = res_bus.last;
        got.outstanding   = res_bus.outstanding;
        got.timer_running = res_bus.timer_running;
        sb.check_result(got);
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_bus.valid && in_bus.ready) || (res_bus.valid && res_bus.ready) ||
          (reg_bus.valid && reg_bus.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("go_back_n_sender_window_core verification failed");
    $finish;
  end

  initial begin : stimulus
    in_bus.valid       = 1'b0;
    in_bus.command     = CMD_OFFER;
    in_bus.payload_tag = '0;
    in_bus.payload_len = '0;
    in_bus.ack_seq     = '0;
    reg_bus.valid      = 1'b0;
    reg_bus.index      = REG_WINDOW_SIZE;
    reg_bus.data       = '0;
    rst_ni             = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset settings: edges of tag and length, stray acks, spare command
    send_item(CMD_OFFER, 16'h0000, 11'd1, SEQ_BITS'($urandom));
    send_item(CMD_OFFER, 16'hFFFF, LEN_BITS'(PAYLOAD_MAX), SEQ_BITS'($urandom));
    send_item(CMD_OFFER, 16'h5A5A, 11'd0, SEQ_BITS'($urandom));
    send_item(CMD_OFFER, TAG_BITS'($urandom), 11'h7FF, SEQ_BITS'($urandom));
    send_item(CMD_OFFER, TAG_BITS'($urandom), 11'd1025, SEQ_BITS'($urandom));
    send_item(CMD_ACK, TAG_BITS'($urandom), LEN_BITS'($urandom), sb.win_base - 1'b1);
    send_item(CMD_ACK, TAG_BITS'($urandom), LEN_BITS'($urandom), 16'hFFFF);
    send_item(CMD_ACK, TAG_BITS'($urandom), LEN_BITS'($urandom), sb.win_next);
    send_item(CMD_SPARE, TAG_BITS'($urandom), LEN_BITS'($urandom), SEQ_BITS'($urandom));
    send_tick();
    send_item(CMD_ACK, TAG_BITS'($urandom), LEN_BITS'($urandom), sb.win_base + 1'b1);

    // window shrunk under the outstanding count, shortest timeout
    wait_idle();
    write_reg(REG_WINDOW_SIZE, 16'd2);
    write_reg(REG_TIMEOUT_MS, 16'd10);
    send_item(CMD_OFFER, TAG_BITS'($urandom), LEN_BITS'($urandom), SEQ_BITS'($urandom));
    send_tick();
    send_item(CMD_ACK, TAG_BITS'($urandom), LEN_BITS'($urandom), sb.win_base);
    send_item(CMD_OFFER, TAG_BITS'($urandom), LEN_BITS'($urandom), SEQ_BITS'($urandom));
    send_item(CMD_ACK, TAG_BITS'($urandom), LEN_BITS'($urandom), sb.win_next - 1'b1);
    send_tick();
    send_item(CMD_OFFER, TAG_BITS'($urandom), 11'd64, SEQ_BITS'($urandom));
    send_tick();
    send_item(CMD_ACK, TAG_BITS'($urandom), LEN_BITS'($urandom), sb.win_base);

    // longest timeout: ticks add up without firing
    wait_idle();
    write_reg(REG_WINDOW_SIZE, 16'd1);
    write_reg(REG_TIMEOUT_MS, 16'hFFFF);
    send_item(CMD_OFFER, TAG_BITS'($urandom), LEN_BITS'($urandom), SEQ_BITS'($urandom));
    for (int i = 0; i < LONG_TICKS; i++) send_tick();
    send_item(CMD_ACK, TAG_BITS'($urandom), LEN_BITS'($urandom), sb.win_base);

    run_phase(16'd4, 16'd30, 65, 45, 25, 25, 20, 20, 25);
    run_phase(16'hFFE0, 16'd10, 55, 40, 25, 30, 30, 0, -1);
    run_phase(16'd16, 16'd60, 75, 50, 10, 38, 0, 30, 40);
    run_phase(16'd31, 16'hFFFF, 55, 55, 25, 15, 20, 20, -1);
    run_phase(16'd2, 16'd20, 65, 30, 30, 35, 25, 25, -1);
    quiet_tail = 1'b1;
    run_phase(CFG_DATA_BITS'($urandom), CFG_DATA_BITS'($urandom_range(10, 60)),
              75, 40, 25, 30, 0, 0, -1);

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    sb.flush_leftovers();
    if (sb.failures == 0) begin
      $display("go_back_n_sender_window_core verification clean");
    end else begin
      $display("go_back_n_sender_window_core verification failed");
    end
    $finish;
  end

endmodule
